// ===== src/assert_macros.svh =====
// Assertion helpers, compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== src/owtm_pkg.sv =====
package owtm_pkg;

    localparam int OWTM_QUEUE_DEPTH = 2;

    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_RESET = 3'd1;
    localparam logic [2:0] CMD_WRITE = 3'd2;
    localparam logic [2:0] CMD_READ  = 3'd3;
    localparam logic [2:0] CMD_TEMP  = 3'd4;

    localparam logic [3:0] PH_IDLE      = 4'd0;
    localparam logic [3:0] PH_RST_LOW   = 4'd1;
    localparam logic [3:0] PH_RST_REL   = 4'd2;
    localparam logic [3:0] PH_PRES_WAIT = 4'd3;
    localparam logic [3:0] PH_PRES_LOW  = 4'd4;
    localparam logic [3:0] PH_W_A       = 4'd5;
    localparam logic [3:0] PH_W_B       = 4'd6;
    localparam logic [3:0] PH_R_STROBE  = 4'd7;
    localparam logic [3:0] PH_R_DELAY   = 4'd8;
    localparam logic [3:0] PH_R_RECOV   = 4'd9;

    localparam logic [2:0] REG_RESET_LOW     = 3'd0;
    localparam logic [2:0] REG_RELEASE_WAIT  = 3'd1;
    localparam logic [2:0] REG_PRESENCE_WAIT = 3'd2;
    localparam logic [2:0] REG_PRESENCE_LOW  = 3'd3;
    localparam logic [2:0] REG_SHORT_LOW     = 3'd4;
    localparam logic [2:0] REG_SLOT          = 3'd5;
    localparam logic [2:0] REG_SAMPLE_DELAY  = 3'd6;
    localparam logic [2:0] REG_READ_RECOVERY = 3'd7;

    localparam logic [7:0] ROM_SKIP   = 8'hCC;
    localparam logic [7:0] CONVERT_T  = 8'h44;
    localparam logic [7:0] READ_SCPAD = 8'hBE;

    typedef struct packed {
        logic [9:0] reset_low_us;
        logic [7:0] release_wait_us;
        logic [9:0] presence_wait_us;
        logic [9:0] presence_low_us;
        logic [5:0] short_low_us;
        logic [7:0] slot_us;
        logic [5:0] sample_delay_us;
        logic [7:0] read_recovery_us;
    } cfg_t;

    localparam cfg_t CFG_DEFAULT = '{
        reset_low_us:     10'd750,
        release_wait_us:  8'd15,
        presence_wait_us: 10'd200,
        presence_low_us:  10'd240,
        short_low_us:     6'd2,
        slot_us:          8'd60,
        sample_delay_us:  6'd12,
        read_recovery_us: 8'd50
    };

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] tx_byte;
        logic       line_level;
    } q_item_t;

    // temperature sequence: reset, skip, convert, reset, skip, read scratchpad, 2 reads
    function automatic logic [3:0] seq_phase(input logic [2:0] step);
        logic [3:0] ph;
        unique case (step)
            3'd0, 3'd3: ph = PH_RST_LOW;
            3'd6, 3'd7: ph = PH_R_STROBE;
            default:    ph = PH_W_A;
        endcase
        return ph;
    endfunction

    function automatic logic [7:0] seq_byte(input logic [2:0] step);
        logic [7:0] b;
        unique case (step)
            3'd1, 3'd4: b = ROM_SKIP;
            3'd2:       b = CONVERT_T;
            3'd5:       b = READ_SCPAD;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

    // raw * 5/8, truncated toward zero
    function automatic logic [15:0] tenths_of(input logic [15:0] raw);
        logic [16:0] mag;
        logic [18:0] prod;
        logic [15:0] t;
        mag  = raw[15] ? (17'h10000 - {1'b0, raw}) : {1'b0, raw};
        prod = {mag, 2'b00} + {2'b00, mag};
        t    = prod[18:3];
        return raw[15] ? (16'd0 - t) : t;
    endfunction

endpackage

// ===== src/one_wire_temp_sensor_master.sv =====
// One-wire bus master stepped by one-microsecond ticks.
// Input channel (s_valid/s_ready): one transfer per tick, carrying s_mode (0 tick,
// 1 reset with presence check, 2 write byte, 3 read byte, 4 read temperature),
// s_tx_byte for writes and s_line_level, the bus level sampled in that tick.
// Output channel (m_valid/m_ready): exactly one transfer per input transfer, in
// order, with the bus drive for the tick, busy/done flags, the presence result,
// the last received byte and the last temperature in tenths of a degree.
// Configuration: cfg_we/cfg_addr/cfg_wdata set the eight timing registers;
// write them only while no tick is in flight.
// Each input transfer passes through a queue slot, then the engine and output
// register, to its result. Throughput: one tick per cycle while the receiver does
// not stall the output; the timing engine updates all of its state at once per tick.
// The input queue keeps accepting while a result waits on a stalled receiver
// until the queue is full; s_ready then drops and no tick is lost.
// Reset (aresetn low, synchronous) empties the queue and the output register,
// idles the engine, clears the presence flag and results and restores default timings.
module one_wire_temp_sensor_master
    import owtm_pkg::*;
#(
    parameter int QUEUE_DEPTH = OWTM_QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [9:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_mode,
    input  logic [7:0]         s_tx_byte,
    input  logic               s_line_level,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_drive_low,
    output logic               m_busy_res,
    output logic               m_done_res,
    output logic               m_device_absent,
    output logic [7:0]         m_rx_byte,
    output logic signed [15:0] m_temp_tenths,
    output logic               m_cmd_rejected
);

    cfg_t    cfg_reg;
    q_item_t q_item;
    logic    q_valid, q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_DEFAULT;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_RESET_LOW:     cfg_reg.reset_low_us     <= cfg_wdata;
                REG_RELEASE_WAIT:  cfg_reg.release_wait_us  <= cfg_wdata[7:0];
                REG_PRESENCE_WAIT: cfg_reg.presence_wait_us <= cfg_wdata;
                REG_PRESENCE_LOW:  cfg_reg.presence_low_us  <= cfg_wdata;
                REG_SHORT_LOW:     cfg_reg.short_low_us     <= cfg_wdata[5:0];
                REG_SLOT:          cfg_reg.slot_us          <= cfg_wdata[7:0];
                REG_SAMPLE_DELAY:  cfg_reg.sample_delay_us  <= cfg_wdata[5:0];
                REG_READ_RECOVERY: cfg_reg.read_recovery_us <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    owtm_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_mode       (s_mode),
        .s_tx_byte    (s_tx_byte),
        .s_line_level (s_line_level),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_item       (q_item)
    );

    owtm_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg_reg),
        .q_valid         (q_valid),
        .q_ready         (q_ready),
        .q_item          (q_item),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_low     (m_drive_low),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_device_absent (m_device_absent),
        .m_rx_byte       (m_rx_byte),
        .m_temp_tenths   (m_temp_tenths),
        .m_cmd_rejected  (m_cmd_rejected)
    );

endmodule

// ===== src/owtm_front.sv =====
module owtm_front
    import owtm_pkg::*;
#(
    parameter int QUEUE_DEPTH = OWTM_QUEUE_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_mode,
    input  logic [7:0] s_tx_byte,
    input  logic       s_line_level,
    output logic       q_valid,
    input  logic       q_ready,
    output q_item_t    q_item
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

    q_item_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;
    q_item_t          in_item;

    always_comb begin
        in_item.tx_byte    = s_tx_byte;
        in_item.line_level = s_line_level;
        unique case (s_mode)
            CMD_RESET: in_item.cmd = CMD_RESET;
            CMD_WRITE: in_item.cmd = CMD_WRITE;
            CMD_READ:  in_item.cmd = CMD_READ;
            CMD_TEMP:  in_item.cmd = CMD_TEMP;
            default:   in_item.cmd = CMD_NONE;
        endcase
    end

    assign s_ready = (count_reg != FULL_CNT);
    assign q_valid = (count_reg != '0);
    assign q_item  = mem[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== src/owtm_back.sv =====
`include "assert_macros.svh"

module owtm_back
    import owtm_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               q_valid,
    output logic               q_ready,
    input  q_item_t            q_item,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_drive_low,
    output logic               m_busy_res,
    output logic               m_done_res,
    output logic               m_device_absent,
    output logic [7:0]         m_rx_byte,
    output logic signed [15:0] m_temp_tenths,
    output logic               m_cmd_rejected
);

    logic [3:0]  phase_reg, phase_next;
    logic [9:0]  us_count_reg, us_count_next;
    logic [2:0]  bit_index_reg, bit_index_next;
    logic [7:0]  shift_reg, shift_next;
    logic [2:0]  step_reg, step_next;
    logic        temp_cmd_reg, temp_cmd_next;
    logic        absent_reg, absent_next;
    logic [7:0]  low_hold_reg, low_hold_next;
    logic [7:0]  last_rx_reg, last_rx_next;
    logic [15:0] last_temp_reg, last_temp_next;

    logic        m_valid_reg;
    logic        drive_reg, busy_reg, done_reg, rejected_reg;
    logic        drive, done, rejected;
    logic        pop;

    always_comb begin
        logic [3:0]  ph;
        logic [9:0]  us;
        logic [9:0]  inc;
        logic [2:0]  bi;
        logic [7:0]  sh;
        logic [2:0]  st;
        logic        tmp;
        logic        sub_end;
        logic        b;

        ph  = phase_reg;
        us  = us_count_reg;
        bi  = bit_index_reg;
        sh  = shift_reg;
        st  = step_reg;
        tmp = temp_cmd_reg;
        absent_next    = absent_reg;
        low_hold_next  = low_hold_reg;
        last_rx_next   = last_rx_reg;
        last_temp_next = last_temp_reg;
        drive    = 1'b0;
        done     = 1'b0;
        rejected = 1'b0;
        sub_end  = 1'b0;

        if (q_item.cmd != CMD_NONE) begin
            if (ph != PH_IDLE) begin
                rejected = 1'b1;
            end else begin
                tmp = (q_item.cmd == CMD_TEMP);
                st  = '0;
                us  = '0;
                bi  = '0;
                unique case (q_item.cmd)
                    CMD_RESET: begin
                        ph = PH_RST_LOW;
                        sh = 8'h00;
                    end
                    CMD_WRITE: begin
                        ph = PH_W_A;
                        sh = q_item.tx_byte;
                    end
                    CMD_READ: begin
                        ph = PH_R_STROBE;
                        sh = 8'h00;
                    end
                    default: begin
                        ph = seq_phase(3'd0);
                        sh = seq_byte(3'd0);
                    end
                endcase
            end
        end

        b   = sh[0];
        inc = us + 10'd1;

        unique case (ph)
            PH_IDLE: begin
            end
            PH_RST_LOW: begin
                drive = 1'b1;
                if (inc >= cfg.reset_low_us || inc == '0) begin
                    us = '0;
                    ph = PH_RST_REL;
                end else begin
                    us = inc;
                end
            end
            PH_RST_REL: begin
                if (inc >= {2'b00, cfg.release_wait_us} || inc == '0) begin
                    us = '0;
                    ph = PH_PRES_WAIT;
                end else begin
                    us = inc;
                end
            end
            PH_PRES_WAIT: begin
                if (us >= cfg.presence_wait_us) begin
                    absent_next = 1'b1;
                    sub_end     = 1'b1;
                end else if (!q_item.line_level) begin
                    ph = PH_PRES_LOW;
                    us = '0;
                end else begin
                    us = inc;
                end
            end
            PH_PRES_LOW: begin
                if (us >= cfg.presence_low_us) begin
                    absent_next = 1'b1;
                    sub_end     = 1'b1;
                end else if (q_item.line_level) begin
                    absent_next = 1'b0;
                    sub_end     = 1'b1;
                end else begin
                    us = inc;
                end
            end
            PH_W_A: begin
                drive = 1'b1;
                if (inc >= (b ? {4'b0, cfg.short_low_us} : {2'b00, cfg.slot_us})
                        || inc == '0) begin
                    us = '0;
                    ph = PH_W_B;
                end else begin
                    us = inc;
                end
            end
            PH_W_B: begin
                if (inc >= (b ? {2'b00, cfg.slot_us} : {4'b0, cfg.short_low_us})
                        || inc == '0) begin
                    us = '0;
                    sh = {1'b0, sh[7:1]};
                    if (bi == 3'd7) begin
                        sub_end = 1'b1;
                    end else begin
                        bi = bi + 3'd1;
                        ph = PH_W_A;
                    end
                end else begin
                    us = inc;
                end
            end
            PH_R_STROBE: begin
                drive = 1'b1;
                if (inc >= {4'b0, cfg.short_low_us} || inc == '0) begin
                    us = '0;
                    ph = PH_R_DELAY;
                end else begin
                    us = inc;
                end
            end
            PH_R_DELAY: begin
                if (inc >= {4'b0, cfg.sample_delay_us} || inc == '0) begin
                    us = '0;
                    ph = PH_R_RECOV;
                end else begin
                    us = inc;
                end
            end
            PH_R_RECOV: begin
                if (us == '0) begin
                    sh = {q_item.line_level, sh[7:1]};
                end
                if (inc >= {2'b00, cfg.read_recovery_us} || inc == '0) begin
                    us = '0;
                    if (bi == 3'd7) begin
                        last_rx_next = sh;
                        if (tmp && st == 3'd6) begin
                            low_hold_next = sh;
                        end else if (tmp && st == 3'd7) begin
                            last_temp_next = tenths_of({sh, low_hold_reg});
                        end
                        sub_end = 1'b1;
                    end else begin
                        bi = bi + 3'd1;
                        ph = PH_R_STROBE;
                    end
                end else begin
                    us = inc;
                end
            end
            default: begin
                ph = PH_IDLE;
            end
        endcase

        if (sub_end) begin
            if (!tmp || st == 3'd7) begin
                ph   = PH_IDLE;
                us   = '0;
                st   = '0;
                done = 1'b1;
            end else begin
                st = st + 3'd1;
                us = '0;
                bi = '0;
                ph = seq_phase(st);
                sh = seq_byte(st);
            end
        end

        phase_next     = ph;
        us_count_next  = us;
        bit_index_next = bi;
        shift_next     = sh;
        step_next      = st;
        temp_cmd_next  = tmp;
    end

    assign q_ready = !m_valid_reg || m_ready;
    assign pop     = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            us_count_reg  <= '0;
            bit_index_reg <= '0;
            shift_reg     <= '0;
            step_reg      <= '0;
            temp_cmd_reg  <= 1'b0;
            absent_reg    <= 1'b0;
            low_hold_reg  <= '0;
            last_rx_reg   <= '0;
            last_temp_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg     <= phase_next;
                us_count_reg  <= us_count_next;
                bit_index_reg <= bit_index_next;
                shift_reg     <= shift_next;
                step_reg      <= step_next;
                temp_cmd_reg  <= temp_cmd_next;
                absent_reg    <= absent_next;
                low_hold_reg  <= low_hold_next;
                last_rx_reg   <= last_rx_next;
                last_temp_reg <= last_temp_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg   <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            drive_reg    <= drive;
            busy_reg     <= (phase_next != PH_IDLE);
            done_reg     <= done;
            rejected_reg <= rejected;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_drive_low     = drive_reg;
    assign m_busy_res      = busy_reg;
    assign m_done_res      = done_reg;
    assign m_cmd_rejected  = rejected_reg;
    assign m_device_absent = absent_reg;
    assign m_rx_byte       = last_rx_reg;
    assign m_temp_tenths   = last_temp_reg;

    `ASSERT_IMPLY(a_done_not_busy, aclk, aresetn, m_valid_reg && done_reg, !busy_reg)
    `ASSERT_IMPLY(a_drive_busy, aclk, aresetn, m_valid_reg && drive_reg, busy_reg)
    `ASSERT_IMPLY(a_idle_count_clear, aclk, aresetn, phase_reg == PH_IDLE, us_count_reg == '0)
    `ASSERT_IMPLY(a_step_only_temp, aclk, aresetn, step_reg != '0, temp_cmd_reg)
    `ASSERT_NEXT(a_reject_keeps_state, aclk, aresetn, pop && rejected, phase_reg != PH_IDLE || m_done_res)

endmodule

// ===== bench/one_wire_temp_sensor_master_tb.sv =====
module one_wire_temp_sensor_master_tb;
    import owtm_pkg::*;

    localparam int CYCLE_LIMIT = 900000;
    localparam int MODE_LAST   = 7;

    localparam cfg_t QUICK_TIMING = '{
        reset_low_us:     10'd4,
        release_wait_us:  8'd2,
        presence_wait_us: 10'd6,
        presence_low_us:  10'd5,
        short_low_us:     6'd1,
        slot_us:          8'd3,
        sample_delay_us:  6'd1,
        read_recovery_us: 8'd2
    };

    typedef struct packed {
        logic        drive_low;
        logic        busy;
        logic        done;
        logic        absent;
        logic [7:0]  rx;
        logic [15:0] temp;
        logic        rejected;
    } tick_result_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_addr = REG_RESET_LOW;
    logic [9:0]         cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [2:0]         s_mode = CMD_NONE;
    logic [7:0]         s_tx_byte = '0;
    logic               s_line_level = 1'b1;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_drive_low;
    logic               m_busy_res;
    logic               m_done_res;
    logic               m_device_absent;
    logic [7:0]         m_rx_byte;
    logic signed [15:0] m_temp_tenths;
    logic               m_cmd_rejected;

    one_wire_temp_sensor_master dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_addr        (cfg_addr),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_tx_byte       (s_tx_byte),
        .s_line_level    (s_line_level),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_drive_low     (m_drive_low),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_device_absent (m_device_absent),
        .m_rx_byte       (m_rx_byte),
        .m_temp_tenths   (m_temp_tenths),
        .m_cmd_rejected  (m_cmd_rejected)
    );

    // bus master mirror
    cfg_t        tm;
    logic [3:0]  ph;
    logic [9:0]  us_cnt;
    logic [2:0]  bit_no;
    logic [7:0]  shreg;
    logic [3:0]  step_no;
    logic [2:0]  cur_cmd;
    logic        absent_q;
    logic [7:0]  low_hold;
    logic [7:0]  rx_last;
    logic [15:0] temp_last;
    logic        finished;

    tick_result_t expected_ticks[$];

    int  send_idle_pct;
    int  recv_idle_pct;
    int  errors = 0;
    int  cycles = 0;
    int  ticks_sent = 0;
    int  results_seen = 0;
    int  cmds_started = 0;
    int  cmds_rejected = 0;
    int  temps_done = 0;
    int  settings_used = 0;
    bit  hold_req = 1'b0;
    int  hold_len = 0;

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d transfers pending", cycles,
                     expected_ticks.size());
            $display("one_wire_temp_sensor_master verification failed");
            $finish;
        end
    end

    function automatic logic [3:0] seq_first_phase(input logic [3:0] s);
        logic [3:0] p;
        case (s)
            4'd0, 4'd3: p = PH_RST_LOW;
            4'd6, 4'd7: p = PH_R_STROBE;
            default:    p = PH_W_A;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] seq_cmd_byte(input logic [3:0] s);
        logic [7:0] b;
        case (s)
            4'd1, 4'd4: b = ROM_SKIP;
            4'd2:       b = CONVERT_T;
            4'd5:       b = READ_SCPAD;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [15:0] raw_to_tenths(input logic [15:0] raw);
        int v;
        int mag;
        int t;
        v = $signed(raw);
        mag = (v < 0) ? -v : v;
        t = (mag * 5) / 8;
        if (v < 0) t = -t;
        return 16'(t);
    endfunction

    function automatic bit phase_over(input logic [9:0] len);
        us_cnt = us_cnt + 10'd1;
        if (us_cnt >= len || us_cnt == 10'd0) begin
            us_cnt = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic reset_mirror();
        tm = CFG_DEFAULT;
        ph = PH_IDLE;
        us_cnt = '0;
        bit_no = '0;
        shreg = '0;
        step_no = '0;
        cur_cmd = CMD_NONE;
        absent_q = 1'b0;
        low_hold = '0;
        rx_last = '0;
        temp_last = '0;
        finished = 1'b0;
    endtask

    task automatic begin_sub(input logic [3:0] first, input logic [7:0] b);
        us_cnt = '0;
        bit_no = '0;
        shreg = b;
        ph = first;
    endtask

    task automatic sub_finish();
        if (cur_cmd != CMD_TEMP) begin
            ph = PH_IDLE;
            us_cnt = '0;
            finished = 1'b1;
        end else begin
            step_no = step_no + 4'd1;
            if (step_no >= 4'd8) begin
                ph = PH_IDLE;
                us_cnt = '0;
                step_no = '0;
                finished = 1'b1;
            end else begin
                begin_sub(seq_first_phase(step_no), seq_cmd_byte(step_no));
            end
        end
    endtask

    task automatic read_complete();
        rx_last = shreg;
        if (cur_cmd == CMD_TEMP) begin
            if (step_no == 4'd6) low_hold = shreg;
            else if (step_no == 4'd7) temp_last = raw_to_tenths({shreg, low_hold});
        end
    endtask

    task automatic run_engine(input logic level, output logic drv);
        logic b;
        b = shreg[0];
        drv = 1'b0;
        case (ph)
            PH_RST_LOW: begin
                drv = 1'b1;
                if (phase_over(tm.reset_low_us)) ph = PH_RST_REL;
            end
            PH_RST_REL: begin
                if (phase_over(10'(tm.release_wait_us))) ph = PH_PRES_WAIT;
            end
            PH_PRES_WAIT: begin
                if (us_cnt >= tm.presence_wait_us) begin
                    absent_q = 1'b1;
                    sub_finish();
                end else if (!level) begin
                    ph = PH_PRES_LOW;
                    us_cnt = '0;
                end else begin
                    us_cnt = us_cnt + 10'd1;
                end
            end
            PH_PRES_LOW: begin
                if (us_cnt >= tm.presence_low_us) begin
                    absent_q = 1'b1;
                    sub_finish();
                end else if (level) begin
                    absent_q = 1'b0;
                    sub_finish();
                end else begin
                    us_cnt = us_cnt + 10'd1;
                end
            end
            PH_W_A: begin
                drv = 1'b1;
                if (phase_over(b ? 10'(tm.short_low_us) : 10'(tm.slot_us))) ph = PH_W_B;
            end
            PH_W_B: begin
                if (phase_over(b ? 10'(tm.slot_us) : 10'(tm.short_low_us))) begin
                    shreg = shreg >> 1;
                    if (bit_no >= 3'd7) begin
                        sub_finish();
                    end else begin
                        bit_no = bit_no + 3'd1;
                        ph = PH_W_A;
                    end
                end
            end
            PH_R_STROBE: begin
                drv = 1'b1;
                if (phase_over(10'(tm.short_low_us))) ph = PH_R_DELAY;
            end
            PH_R_DELAY: begin
                if (phase_over(10'(tm.sample_delay_us))) ph = PH_R_RECOV;
            end
            PH_R_RECOV: begin
                if (us_cnt == 10'd0) shreg = {level, shreg[7:1]};
                if (phase_over(10'(tm.read_recovery_us))) begin
                    if (bit_no >= 3'd7) begin
                        read_complete();
                        sub_finish();
                    end else begin
                        bit_no = bit_no + 3'd1;
                        ph = PH_R_STROBE;
                    end
                end
            end
            default: begin
                ph = PH_IDLE;
            end
        endcase
    endtask

    task automatic predict_tick(input logic [2:0] mode, input logic [7:0] tx,
                                input logic level, output tick_result_t r);
        logic drv;
        drv = 1'b0;
        finished = 1'b0;
        r.rejected = 1'b0;
        if (mode >= CMD_RESET && mode <= CMD_TEMP) begin
            if (ph != PH_IDLE) begin
                r.rejected = 1'b1;
                cmds_rejected++;
            end else begin
                cur_cmd = mode;
                step_no = '0;
                cmds_started++;
                case (mode)
                    CMD_RESET: begin_sub(PH_RST_LOW, 8'h00);
                    CMD_WRITE: begin_sub(PH_W_A, tx);
                    CMD_READ:  begin_sub(PH_R_STROBE, 8'h00);
                    default:   begin_sub(seq_first_phase(4'd0), seq_cmd_byte(4'd0));
                endcase
            end
        end
        if (ph != PH_IDLE) run_engine(level, drv);
        if (finished && cur_cmd == CMD_TEMP) temps_done++;
        r.drive_low = drv;
        r.busy = (ph != PH_IDLE);
        r.done = finished;
        r.absent = absent_q;
        r.rx = rx_last;
        r.temp = temp_last;
    endtask

    task automatic send_tick(input logic [2:0] mode, input logic [7:0] tx, input logic level);
        tick_result_t r;
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_tx_byte <= tx;
        s_line_level <= level;
        do @(posedge aclk); while (!s_ready);
        predict_tick(mode, tx, level, r);
        expected_ticks.push_back(r);
        ticks_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [9:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
    endtask

    task automatic load_timing(input cfg_t c);
        drain();
        write_reg(REG_RESET_LOW, c.reset_low_us);
        write_reg(REG_RELEASE_WAIT, 10'(c.release_wait_us));
        write_reg(REG_PRESENCE_WAIT, c.presence_wait_us);
        write_reg(REG_PRESENCE_LOW, c.presence_low_us);
        write_reg(REG_SHORT_LOW, 10'(c.short_low_us));
        write_reg(REG_SLOT, 10'(c.slot_us));
        write_reg(REG_SAMPLE_DELAY, 10'(c.sample_delay_us));
        write_reg(REG_READ_RECOVERY, 10'(c.read_recovery_us));
        @(negedge aclk);
        cfg_we <= 1'b0;
        tm = c;
        settings_used++;
    endtask

    // scripted slave: presence pulse starts at pres_at and lasts pres_len,
    // read slots return bits of pattern (high byte for the second temp read)
    function automatic logic slave_level(input int pres_at, input int pres_len,
                                         input logic [15:0] pattern);
        int idx;
        idx = int'(bit_no);
        if (cur_cmd == CMD_TEMP && step_no == 4'd7) idx = idx + 8;
        if (ph == PH_PRES_WAIT && int'(us_cnt) >= pres_at) return 1'b0;
        if (ph == PH_PRES_LOW && int'(us_cnt) < pres_len) return 1'b0;
        if (ph == PH_R_RECOV) return pattern[idx];
        return 1'b1;
    endfunction

    task automatic advance_command(input int n_ticks, input int pres_at, input int pres_len,
                                   input logic [15:0] pattern);
        for (int i = 0; i < n_ticks && ph != PH_IDLE; i++)
            send_tick(CMD_NONE, 8'($urandom), slave_level(pres_at, pres_len, pattern));
    endtask

    task automatic finish_command(input int pres_at, input int pres_len,
                                  input logic [15:0] pattern);
        while (ph != PH_IDLE)
            send_tick(CMD_NONE, 8'($urandom), slave_level(pres_at, pres_len, pattern));
    endtask

    task automatic run_cmd(input logic [2:0] mode, input logic [7:0] tx, input int pres_at,
                           input int pres_len, input logic [15:0] pattern);
        send_tick(mode, tx, 1'b1);
        finish_command(pres_at, pres_len, pattern);
    endtask

    task automatic random_tick();
        logic [2:0] mode;
        logic       lvl;
        int         p;
        p = $urandom_range(99);
        if (p < 8) begin
            mode = 3'($urandom);
            lvl = 1'($urandom);
        end else begin
            if (ph == PH_IDLE) begin
                if (p < 45) mode = CMD_TEMP;
                else if (p < 85) mode = 3'($urandom_range(CMD_RESET, CMD_TEMP));
                else mode = 3'($urandom_range(CMD_NONE, MODE_LAST));
            end else begin
                mode = (p < 14) ? 3'($urandom_range(CMD_RESET, MODE_LAST)) : CMD_NONE;
            end
            case (ph)
                PH_PRES_WAIT: lvl = ($urandom_range(99) >= 25);
                PH_PRES_LOW:  lvl = ($urandom_range(99) < 30);
                default:      lvl = 1'($urandom);
            endcase
        end
        send_tick(mode, 8'($urandom), lvl);
    endtask

    // long default slots: run the first bits, then finish on quick timing
    task automatic test_default_timing();
        send_tick(CMD_WRITE, 8'h3C, 1'b1);
        advance_command(70, 0, 0, 16'h0000);
        load_timing(QUICK_TIMING);
        finish_command(0, 0, 16'h0000);
        load_timing(CFG_DEFAULT);
        send_tick(CMD_READ, 8'h00, 1'b1);
        advance_command(70, 0, 0, 16'h0069);
        load_timing(QUICK_TIMING);
        finish_command(0, 0, 16'h0069);
    endtask

    task automatic test_timing_max();
        cfg_t c;
        c = '{reset_low_us: 10'd1023, release_wait_us: 8'd255, presence_wait_us: 10'd1023,
              presence_low_us: 10'd1023, short_low_us: 6'd63, slot_us: 8'd255,
              sample_delay_us: 6'd63, read_recovery_us: 8'd255};
        load_timing(c);
        send_tick(CMD_READ, 8'h00, 1'b1);
        advance_command(135, 0, 0, 16'h0096);            // first sample at the longest delay
        load_timing(QUICK_TIMING);
        finish_command(0, 0, 16'h0096);
    endtask

    task automatic test_timing_zero();
        load_timing('0);
        run_cmd(CMD_RESET, 8'h00, 0, 0, 16'h0000);       // zero limit fails at once
        run_cmd(CMD_TEMP, 8'h00, 0, 0, 16'h8000);
    endtask

    task automatic test_commands();
        load_timing(QUICK_TIMING);
        run_cmd(CMD_RESET, 8'h00, 2, 3, 16'h0000);
        run_cmd(CMD_RESET, 8'h00, 100, 0, 16'h0000);
        run_cmd(CMD_RESET, 8'h00, 1, 100, 16'h0000);
        run_cmd(CMD_TEMP, 8'h00, 1, 2, 16'hFFF3);        // negative, truncated toward zero
        // commands and unused modes while busy
        send_tick(CMD_WRITE, 8'h81, 1'b1);
        for (int m = CMD_RESET; m <= MODE_LAST; m++) send_tick(3'(m), 8'h7E, 1'b0);
        finish_command(0, 0, 16'h0000);
        for (int m = CMD_TEMP + 1; m <= MODE_LAST; m++) send_tick(3'(m), 8'hC3, 1'b1);
    endtask

    task automatic test_random(input int n_items);
        cfg_t c;
        c.reset_low_us = 10'($urandom_range(0, 6));
        c.release_wait_us = 8'($urandom_range(0, 3));
        c.presence_wait_us = 10'($urandom_range(0, 8));
        c.presence_low_us = 10'($urandom_range(0, 8));
        c.short_low_us = 6'($urandom_range(0, 3));
        c.slot_us = 8'($urandom_range(0, 6));
        c.sample_delay_us = 6'($urandom_range(0, 3));
        c.read_recovery_us = 8'($urandom_range(0, 4));
        load_timing(c);
        repeat (n_items) random_tick();
        finish_command($urandom_range(0, 4), $urandom_range(0, 6), 16'($urandom));
    endtask

    task automatic test_backpressure();
        int keep;
        drain();
        keep = send_idle_pct;
        send_idle_pct = 0;
        hold_len = 60;
        hold_req = 1'b1;
        repeat (24) random_tick();
        send_idle_pct = keep;
        drain();
        repeat (12) random_tick();
        finish_command(1, 2, 16'($urandom));
    endtask

    // receiver: random stalls, or a counted hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (hold_len - 1) @(negedge aclk);
                hold_req = 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", results_seen, what, got, want);
        errors++;
    endtask

    always @(posedge aclk) begin : check_results
        tick_result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_ticks.size() == 0) begin
                report_mismatch("transfer with no tick pending", 16'd1, 16'd0);
            end else begin
                want = expected_ticks.pop_front();
                if (m_drive_low !== want.drive_low)
                    report_mismatch("drive_low", 16'(m_drive_low), 16'(want.drive_low));
                if (m_busy_res !== want.busy)
                    report_mismatch("busy_res", 16'(m_busy_res), 16'(want.busy));
                if (m_done_res !== want.done)
                    report_mismatch("done_res", 16'(m_done_res), 16'(want.done));
                if (m_device_absent !== want.absent)
                    report_mismatch("device_absent", 16'(m_device_absent), 16'(want.absent));
                if (m_rx_byte !== want.rx)
                    report_mismatch("rx_byte", 16'(m_rx_byte), 16'(want.rx));
                if (m_temp_tenths !== want.temp)
                    report_mismatch("temp_tenths", m_temp_tenths, want.temp);
                if (m_cmd_rejected !== want.rejected)
                    report_mismatch("cmd_rejected", 16'(m_cmd_rejected), 16'(want.rejected));
            end
        end
    end

    initial begin
        send_idle_pct = 27;
        recv_idle_pct = 71;
        reset_mirror();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_default_timing();
        test_timing_max();
        test_timing_zero();
        test_commands();
        test_random(20);

        send_idle_pct = 71;
        recv_idle_pct = 27;
        test_backpressure();
        test_random(20);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(20);

        drain();
        repeat (10) @(posedge aclk);
        if (expected_ticks.size() != 0)
            report_mismatch("ticks left without result", 16'(expected_ticks.size()), 16'd0);

        $display("%0d ticks sent, %0d results checked, %0d commands run, %0d rejected busy",
                 ticks_sent, results_seen, cmds_started, cmds_rejected);
        $display("%0d temperature reads over defaults plus %0d loaded timing sets",
                 temps_done, settings_used);
        if (errors == 0) begin
            $display("one_wire_temp_sensor_master verification clean");
        end else begin
            $display("one_wire_temp_sensor_master verification failed");
        end
        $finish;
    end

endmodule
